>>> sv/mbtm_pkg.sv
// Shared types and codes for the mixing buffer tolerance match block.
// Used by mbtm_cell and mixing_buffer_tolerance_match_top; no dependencies.
package mbtm_pkg;

	// Default number of stored events
	localparam int NUM_MIXED_DEF = 4;

	// Key widths
	localparam int MULT_W = 12;
	localparam int Z_W    = 16;
	localparam int RATE_W = 20;
	localparam int ZTOL_W = 15;

	// Operation codes carried in s_tuser
	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_FIND   = 2'd1;
	localparam logic [1:0] FUNC_REWIND = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_MULT_TOL = 2'd0;
	localparam logic [1:0] CFG_Z_TOL    = 2'd1;
	localparam logic [1:0] CFG_RATE_TOL = 2'd2;

	// Event keys of one stored entry or of a reference event
	typedef struct packed {
		logic [MULT_W-1:0] mult;
		logic signed [Z_W-1:0] vertex_z;
		logic [RATE_W-1:0] rate;
	} keys_t;

	// Tolerance registers broadcast to every cell
	typedef struct packed {
		logic [MULT_W-1:0] mult;
		logic [ZTOL_W-1:0] z;
		logic [RATE_W-1:0] rate;
	} tol_t;

	// Status a cell reports to the search sequencer
	typedef struct packed {
		logic valid;
		logic hit;
	} cell_stat_t;

endpackage

>>> sv/mbtm_cell.sv
// One slot of the event shift chain: holds an entry and checks it against
// the reference keys within the tolerances. Depends on mbtm_pkg.
module mbtm_cell import mbtm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic       prev_valid,
	input  keys_t      prev_keys,
	input  keys_t      ref_keys,
	input  tol_t       tol,
	output logic       valid,
	output keys_t      keys,
	output cell_stat_t stat
);

	logic              valid_q;
	keys_t             keys_q;
	logic [MULT_W-1:0] mult_diff;
	logic signed [Z_W:0] z_diff;
	logic [Z_W:0]      z_abs;
	logic [RATE_W-1:0] rate_diff;

	// Take the neighbor's valid bit on an add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= prev_valid;
		end
	end

	// Take the neighbor's keys on an add
	always_ff @(posedge clk) begin
		if (shift_en) begin
			keys_q <= prev_keys;
		end
	end

	// Absolute key differences
	always_comb begin
		mult_diff = (ref_keys.mult >= keys_q.mult) ? ref_keys.mult - keys_q.mult
		                                           : keys_q.mult - ref_keys.mult;
		z_diff    = {ref_keys.vertex_z[Z_W-1], ref_keys.vertex_z}
		          - {keys_q.vertex_z[Z_W-1], keys_q.vertex_z};
		z_abs     = z_diff[Z_W] ? (Z_W+1)'(-z_diff) : z_diff;
		rate_diff = (ref_keys.rate >= keys_q.rate) ? ref_keys.rate - keys_q.rate
		                                           : keys_q.rate - ref_keys.rate;
	end

	assign stat.valid = valid_q;
	assign stat.hit   = (mult_diff <= tol.mult) && (z_abs <= (Z_W+1)'(tol.z))
	                 && (rate_diff <= tol.rate);
	assign valid      = valid_q;
	assign keys       = keys_q;

endmodule

>>> sv/mixing_buffer_tolerance_match_top.sv
// Top level of the mixing buffer tolerance match block: cell chain, search
// sequencer, tolerance registers and output register. Depends on mbtm_pkg, mbtm_cell.
//
// The block keeps the keys of the NUM_MIXED most recent events in a chain of
// cells, slot 0 the newest. An add or a rewind gives no result. During a
// query the block is not ready: the sequencer inspects one slot per cycle,
// starting at the search cursor, every cell comparing its entry against the
// reference keys in parallel, and stops at the first match, the first empty
// slot or the end of the buffer. One result per query leaves through an
// output register, so a new item is taken while the result still waits; a
// search that has finished holds until that register is free.
module mixing_buffer_tolerance_match_top import mbtm_pkg::*; #(
	parameter int NUM_MIXED = NUM_MIXED_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata from bit 0: mult[11:0], vertex_z[15:0], coinc_rate[19:0]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	// s_tuser: func[1:0]
	input  logic [1:0]  s_tuser,
	// m_tdata from bit 0: slot[3:0], match_mult[11:0], match_vertex_z[15:0],
	// match_rate[19:0], zero padding[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,
	// m_tuser: found
	output logic [0:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	localparam int CW = $clog2(NUM_MIXED + 1);
	localparam int IW = (NUM_MIXED > 1) ? $clog2(NUM_MIXED) : 1;

	typedef enum logic {ST_IDLE, ST_SEARCH} state_t;

	state_t           state_q;
	logic [CW-1:0]    cursor_q;
	tol_t             tol_q;
	keys_t            ref_q;
	keys_t            in_keys;
	logic             m_tvalid_q;
	logic [55:0]      m_tdata_q;
	logic             found_q;

	logic             valid_w [NUM_MIXED];
	keys_t            keys_w  [NUM_MIXED];
	cell_stat_t       stat_w  [NUM_MIXED];

	logic             in_xfer;
	logic             add_en;
	logic             at_end;
	logic [IW-1:0]    cur_idx;
	cell_stat_t       cur_stat;
	keys_t            cur_keys;
	logic             done;
	logic             out_free;
	logic             finish;

	assign in_keys.mult     = s_tdata[11:0];
	assign in_keys.vertex_z = s_tdata[27:12];
	assign in_keys.rate     = s_tdata[47:28];

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign add_en   = in_xfer && (s_tuser == FUNC_ADD);

	// Chain of cells, each taking its neighbor's entry on an add
	for (genvar i = 0; i < NUM_MIXED; i++) begin : g_cell
		if (i == 0) begin : g_head
			mbtm_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.shift_en   (add_en),
				.prev_valid (1'b1),
				.prev_keys  (in_keys),
				.ref_keys   (ref_q),
				.tol        (tol_q),
				.valid      (valid_w[i]),
				.keys       (keys_w[i]),
				.stat       (stat_w[i])
			);
		end else begin : g_body
			mbtm_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.shift_en   (add_en),
				.prev_valid (valid_w[i-1]),
				.prev_keys  (keys_w[i-1]),
				.ref_keys   (ref_q),
				.tol        (tol_q),
				.valid      (valid_w[i]),
				.keys       (keys_w[i]),
				.stat       (stat_w[i])
			);
		end
	end

	// Select the slot under the cursor
	always_comb begin
		at_end   = (cursor_q == CW'(NUM_MIXED));
		cur_idx  = cursor_q[IW-1:0];
		cur_stat = stat_w[cur_idx];
		cur_keys = keys_w[cur_idx];
		done     = at_end || !cur_stat.valid || cur_stat.hit;
		out_free = !m_tvalid_q || m_tready;
		finish   = (state_q == ST_SEARCH) && done && out_free;
	end

	// Latch the reference keys of a query
	always_ff @(posedge clk) begin
		if (in_xfer && (s_tuser == FUNC_FIND)) begin
			ref_q <= in_keys;
		end
	end

	// Sequencer state, cursor, tolerances and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cursor_q   <= '0;
			tol_q.mult <= MULT_W'(100);
			tol_q.z    <= '0;
			tol_q.rate <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			found_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MULT_TOL: tol_q.mult <= cfg_data[MULT_W-1:0];
					CFG_Z_TOL:    tol_q.z    <= cfg_data[ZTOL_W-1:0];
					CFG_RATE_TOL: tol_q.rate <= cfg_data[RATE_W-1:0];
					default:      ;
				endcase
			end
			// Load the result when a search finishes, drop it after its transfer
			if (finish) begin
				m_tvalid_q <= 1'b1;
				found_q    <= !at_end && cur_stat.valid && cur_stat.hit;
				if (!at_end && cur_stat.valid && cur_stat.hit) begin
					m_tdata_q <= {4'd0, cur_keys.rate, cur_keys.vertex_z, cur_keys.mult,
					              4'(cursor_q)};
				end else begin
					m_tdata_q <= '0;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && s_tuser == FUNC_FIND) begin
						state_q <= ST_SEARCH;
					end else if (in_xfer && s_tuser == FUNC_REWIND) begin
						cursor_q <= '0;
					end
				end
				ST_SEARCH: begin
					if (done) begin
						if (out_free) begin
							state_q <= ST_IDLE;
							if (!at_end) begin
								cursor_q <= cursor_q + 1'b1;
							end
						end
					end else begin
						cursor_q <= cursor_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = found_q;

`ifndef SYNTHESIS
	// Cursor saturates at the end marker
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CW'(NUM_MIXED))
		else $error("search cursor past end of buffer");

	// A match always names a real slot
	a_found_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && found_q |-> m_tdata_q[3:0] < 4'(NUM_MIXED))
		else $error("match reported outside the buffer");

	// Not-found results carry zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !found_q |-> m_tdata_q == '0)
		else $error("not-found result with nonzero fields");

	// An add leaves a valid entry in slot 0
	a_add_head: assert property (@(posedge clk) disable iff (!arst_n)
		add_en |=> valid_w[0])
		else $error("slot 0 invalid after add");

	// A query transfer starts a search
	a_query_search: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && s_tuser == FUNC_FIND |=> state_q == ST_SEARCH)
		else $error("query did not start a search");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for mixing_buffer_tolerance_match_top: directed table, partly with fixed expected
// results, then random phases under several tolerance settings; the rest checked against a local predictor.
// Depends on mbtm_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;
	import mbtm_pkg::*;

	localparam int SLOTS = NUM_MIXED_DEF;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int RAND_PER_PHASE = 110;
	localparam int LONG_HOLD = 50;

	typedef struct packed {
		logic [1:0] func;
		keys_t keys;
	} event_item_t;

	typedef struct packed {
		logic found;
		logic [3:0] slot;
		keys_t keys;
	} match_result_t;

	typedef struct packed {
		event_item_t item;
		logic typed;
		match_result_t res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [19:0] cfg_data;

	// Shadow of the event buffer, cursor and tolerances
	logic  ev_valid [SLOTS];
	keys_t ev_keys [SLOTS];
	int    cursor;
	int    tol_mult;
	int    tol_z;
	int    tol_rate;

	match_result_t expected_matches[$];
	int  mismatches;
	bit  tx_idle_on;
	bit  rx_idle_on;
	int  hold_seq;

	mixing_buffer_tolerance_match_top #(
		.NUM_MIXED(SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(string what, longint got, longint want);
		if (mismatches < 50) begin
			$display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		end
		mismatches++;
	endtask

	// Apply one event to the shadow buffer; a query yields one result
	task automatic predict_event(input event_item_t it, output bit has_res,
			output match_result_t res);
		int s;
		int dm;
		int dz;
		int dr;
		bit done;
		has_res = 1'b0;
		res = '0;
		case (it.func)
			FUNC_ADD: begin
				for (s = SLOTS - 1; s > 0; s--) begin
					ev_valid[s] = ev_valid[s-1];
					ev_keys[s] = ev_keys[s-1];
				end
				ev_valid[0] = 1'b1;
				ev_keys[0] = it.keys;
			end
			FUNC_REWIND: begin
				cursor = 0;
			end
			FUNC_FIND: begin
				has_res = 1'b1;
				done = 1'b0;
				s = cursor;
				while (!done && s < SLOTS) begin
					dm = int'(it.keys.mult) - int'(ev_keys[s].mult);
					dz = int'($signed(it.keys.vertex_z)) - int'($signed(ev_keys[s].vertex_z));
					dr = int'(it.keys.rate) - int'(ev_keys[s].rate);
					if (dm < 0) dm = -dm;
					if (dz < 0) dz = -dz;
					if (dr < 0) dr = -dr;
					if (!ev_valid[s]) begin
						done = 1'b1;
					end else if (dm <= tol_mult && dz <= tol_z && dr <= tol_rate) begin
						res.found = 1'b1;
						res.slot = s[3:0];
						res.keys = ev_keys[s];
						done = 1'b1;
					end
					s++;
				end
				// stop at a match or empty slot leaves it one past; the end saturates
				cursor = s;
			end
			default: ;
		endcase
	endtask

	function automatic dir_row_t row(logic [1:0] f, int m, int z, int r, bit typed,
			bit fnd, int sl, int em, int ez, int er);
		dir_row_t d;
		d.item.func = f;
		d.item.keys.mult = m[11:0];
		d.item.keys.vertex_z = z[15:0];
		d.item.keys.rate = r[19:0];
		d.typed = typed;
		d.res.found = fnd;
		d.res.slot = sl[3:0];
		d.res.keys.mult = em[11:0];
		d.res.keys.vertex_z = ez[15:0];
		d.res.keys.rate = er[19:0];
		return d;
	endfunction

	// Offset a key to land on, just inside or just outside the tolerance
	function automatic int nudge(int v, int tol);
		case ($urandom_range(0, 5))
			0: return v - tol - 1;
			1: return v - tol;
			2: return v;
			3: return v + tol;
			4: return v + tol + 1;
			default: return v + int'($urandom_range(0, 2 * tol)) - tol;
		endcase
	endfunction

	// Mostly adds, rewinds and queries near stored keys; some noise
	function automatic event_item_t next_random_event();
		event_item_t it;
		int k;
		int pick;
		int tmp;
		it.keys.mult = 12'($urandom_range(0, 4095));
		it.keys.vertex_z = 16'($urandom_range(0, 65535));
		it.keys.rate = 20'($urandom_range(0, 1048575));
		k = $urandom_range(0, 99);
		pick = $urandom_range(0, SLOTS - 1);
		if (k < 92 && (k < 30 || k >= 45) && ev_valid[pick] && $urandom_range(0, 3) != 0) begin
			tmp = nudge(int'(ev_keys[pick].mult), tol_mult);
			it.keys.mult = tmp[11:0];
			tmp = nudge(int'($signed(ev_keys[pick].vertex_z)), tol_z);
			it.keys.vertex_z = tmp[15:0];
			tmp = nudge(int'(ev_keys[pick].rate), tol_rate);
			it.keys.rate = tmp[19:0];
		end
		if (k < 30)
			it.func = FUNC_ADD;
		else if (k < 45)
			it.func = FUNC_REWIND;
		else if (k < 92)
			it.func = FUNC_FIND;
		else
			it.func = ($urandom_range(0, 1) != 0) ? FUNC_UNUSED : FUNC_FIND;
		return it;
	endfunction

	// Offer one event until transfer, then log the expected result
	task automatic send_item(event_item_t it, bit typed, match_result_t typed_res);
		bit has_res;
		match_result_t res;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {it.keys.rate, it.keys.vertex_z, it.keys.mult};
		s_tuser = it.func;
		do @(posedge clk); while (!s_tready);
		predict_event(it, has_res, res);
		if (has_res) expected_matches.push_back(typed ? typed_res : res);
		@(negedge clk);
	endtask

	// Hold off until every result is back and the block has settled
	task automatic wait_drain();
		s_tvalid = 1'b0;
		while (expected_matches.size() != 0) @(negedge clk);
		repeat (SLOTS + 4) @(negedge clk);
	endtask

	task automatic set_tolerances(int m, int z, int r);
		cfg_we = 1'b1;
		cfg_index = CFG_MULT_TOL;
		cfg_data = 20'(m);
		@(negedge clk);
		cfg_index = CFG_Z_TOL;
		cfg_data = 20'(z);
		@(negedge clk);
		cfg_index = CFG_RATE_TOL;
		cfg_data = 20'(r);
		@(negedge clk);
		cfg_we = 1'b0;
		tol_mult = m & 32'hFFF;
		tol_z = z & 32'h7FFF;
		tol_rate = r & 32'hFFFFF;
	endtask

	// Receiver side: short random stalls plus an occasional long hold-off
	initial begin : rx_side
		int gap;
		int hold;
		int seen_seq;
		m_tready = 1'b0;
		gap = 0;
		hold = 0;
		seen_seq = 0;
		forever begin
			@(negedge clk);
			if (hold_seq != seen_seq) begin
				seen_seq = hold_seq;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				hold--;
				m_tready = 1'b0;
			end else if (gap > 0) begin
				gap--;
				m_tready = 1'b0;
			end else if (rx_idle_on && arst_n && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(0, 2);
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		match_result_t got;
		match_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.found = m_tuser[0];
			got.slot = m_tdata[3:0];
			got.keys.mult = m_tdata[15:4];
			got.keys.vertex_z = m_tdata[31:16];
			got.keys.rate = m_tdata[51:32];
			if (expected_matches.size() == 0) begin
				report_mismatch("unexpected result, found", got.found, -1);
			end else begin
				want = expected_matches.pop_front();
				if (got.found !== want.found)
					report_mismatch("found", got.found, want.found);
				if (got.slot !== want.slot)
					report_mismatch("slot", got.slot, want.slot);
				if (got.keys.mult !== want.keys.mult)
					report_mismatch("match_mult", got.keys.mult, want.keys.mult);
				if (got.keys.vertex_z !== want.keys.vertex_z)
					report_mismatch("match_vertex_z", $signed(got.keys.vertex_z),
						$signed(want.keys.vertex_z));
				if (got.keys.rate !== want.keys.rate)
					report_mismatch("match_rate", got.keys.rate, want.keys.rate);
			end
		end
	end

	// Stop a hung run
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : main_flow
		dir_row_t dir_tab[$];
		int i;
		int p;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FUNC_ADD;
		cfg_we = 1'b0;
		cfg_index = CFG_MULT_TOL;
		cfg_data = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_seq = 0;
		mismatches = 0;
		for (i = 0; i < SLOTS; i++) begin
			ev_valid[i] = 1'b0;
			ev_keys[i] = '0;
		end
		cursor = 0;
		tol_mult = 100;
		tol_z = 0;
		tol_rate = 0;

		// Directed table under reset tolerances (mult 100, z 0, rate 0)
		dir_tab.push_back(row(FUNC_FIND, 0, 0, 0, 1, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_FIND, 4095, -1, 1048575, 1, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_REWIND, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_ADD, 4095, -32768, 1048575, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_UNUSED, 4095, -1, 1048575, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_FIND, 4095, -32768, 1048575, 1,
			1, 0, 4095, -32768, 1048575));
		dir_tab.push_back(row(FUNC_FIND, 0, 0, 0, 1, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_REWIND, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_ADD, 0, 32767, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_FIND, 100, 32767, 0, 1, 1, 0, 0, 32767, 0));
		// add between two queries: cursor stays put
		dir_tab.push_back(row(FUNC_ADD, 50, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_FIND, 101, 32767, 0, 0, 0, 0, 0, 0, 0));
		// cursor saturated at the end
		dir_tab.push_back(row(FUNC_FIND, 0, 0, 0, 1, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_REWIND, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_FIND, 4095, -32768, 1048575, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_ADD, 1, 1, 1, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_ADD, 2, -1, 2, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_REWIND, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_FIND, 0, 32767, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_FIND, 0, 0, 0, 1, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_REWIND, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// full buffer, nothing matches: run to the end
		dir_tab.push_back(row(FUNC_FIND, 2048, -32768, 1048575, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(FUNC_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (i = 0; i < dir_tab.size(); i++)
			send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
		wait_drain();

		// Random phases, each under its own tolerance setting
		for (p = 0; p < 5; p++) begin
			case (p)
				0: set_tolerances(0, 0, 0);
				1: set_tolerances(4095, 32767, 1048575);
				2: set_tolerances($urandom_range(0, 4095), $urandom_range(0, 32767),
					$urandom_range(0, 1048575));
				3: set_tolerances($urandom_range(0, 20), $urandom_range(0, 200),
					$urandom_range(0, 2000));
				default: set_tolerances(100, $urandom_range(0, 300), $urandom_range(0, 5000));
			endcase
			// no idling in the last phase
			tx_idle_on = (p < 4);
			rx_idle_on = (p < 4);
			if (p == 0 || p == 2) hold_seq++;
			for (i = 0; i < RAND_PER_PHASE; i++)
				send_item(next_random_event(), 1'b0, '0);
			wait_drain();
		end

		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> mixing_buffer_tolerance_match_top.f
sv/mbtm_pkg.sv
sv/mbtm_cell.sv
sv/mixing_buffer_tolerance_match_top.sv
test/testbench.sv
